### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the smoothing filter RTL
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define WSF_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Implication: post checked in the cycle after pre
`define WSF_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### rtl/wsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsf_pkg
// Types and fixed constants of the weighted 3x3 smoothing filter.
// ----------------------------------------------------------------------------
package wsf_pkg;

	// field widths
	localparam int PIX_W       = 8;
	localparam int ROW_W       = 16;
	localparam int COL_OUT_W   = 10;
	localparam int WIDTH_REG_W = 11;
	localparam int CFG_W       = 16;

	// register indexes
	localparam logic CFG_IDX_WIDTH  = 1'b0;
	localparam logic CFG_IDX_HEIGHT = 1'b1;

	// results per transaction
	localparam int MAX_RUN   = 3;
	localparam int RUN_CNT_W = 2;

	// window sum and divide by ten: floor(x / 10) == (x * 6554) >> 16 for x < 16384
	localparam int              SUM_W       = 12;
	localparam int              MUL_W       = 13;
	localparam logic [MUL_W-1:0] DIV10_MUL  = 13'd6554;
	localparam int              DIV10_SHIFT = 16;

	// result queue depth (power of two)
	localparam int RESQ_DEPTH = 16;

	typedef struct packed {
		logic [PIX_W-1:0]     pixel;
		logic [ROW_W-1:0]     row;
		logic [COL_OUT_W-1:0] col;
		logic                 last;
	} res_t;

	// up to three results pushed into the queue in one cycle
	typedef struct packed {
		logic [RUN_CNT_W-1:0]   n;
		res_t [MAX_RUN-1:0]     item;
	} res_push_t;

	// position of a pixel inside the frame
	typedef struct packed {
		logic row_first;
		logic row_ge2;
		logic row_last;
		logic col_first;
		logic col_ge2;
		logic col_last;
	} pos_flags_t;

endpackage

### rtl/wsf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wsf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/wsf_resq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsf_resq
// Result queue: takes up to three results per cycle, hands out one.
// ----------------------------------------------------------------------------
module wsf_resq #(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wsf_pkg::res_push_t         push,
	input  logic                       pop,
	output wsf_pkg::res_t              head,
	output logic                       head_valid,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	wsf_pkg::res_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_pop;

	assign do_pop     = pop && (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign count      = count_q;

	// storage: consecutive slots from the write pointer
	always_ff @(posedge clk) begin
		for (int i = 0; i < wsf_pkg::MAX_RUN; i++) begin
			if (wsf_pkg::RUN_CNT_W'(i) < push.n) begin
				mem_q[wr_ptr_q + PW'(i)] <= push.item[i];
			end
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push.n);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CW'(push.n) - CW'(do_pop);
		end
	end

endmodule

### rtl/weighted_3x3_smoothing_filter.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// weighted_3x3_smoothing_filter
// 3x3 smoothing with doubled center weight over a raster pixel stream.
// Border rows pass through, border columns give zero.
//
// Channel  Direction  Handshake                Payload
// input    in         in_valid / in_ready      pixel_in
// output   out        out_valid / out_ready    pixel_out, out_row, out_col, last_of_run
// config   in         cfg_we                   cfg_index, cfg_wdata
//
// One pixel per cycle is accepted while in_ready is high; its results enter the
// queue from stage 2 (stage 1: line store read and window sum, stage 2: divide by ten).
// in_ready drops when the 16-entry result queue cannot hold three results for
// each transaction in flight plus the new one; row ends give up to three results.
// The line stores are one RAM of two pixels per column, not cleared by reset.
// A register write restarts the frame at row 0, column 0.
// ----------------------------------------------------------------------------
module weighted_3x3_smoothing_filter #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// pixel input
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [wsf_pkg::PIX_W-1:0]         pixel_in,
	// result output
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [wsf_pkg::PIX_W-1:0]         pixel_out,
	output logic [wsf_pkg::ROW_W-1:0]         out_row,
	output logic [wsf_pkg::COL_OUT_W-1:0]     out_col,
	output logic                              last_of_run,
	// configuration
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [wsf_pkg::CFG_W-1:0]         cfg_wdata
);

	localparam int CW        = $clog2(MAX_WIDTH);
	localparam int RW        = wsf_pkg::ROW_W;
	localparam int PW        = wsf_pkg::PIX_W;
	localparam int QCW       = $clog2(wsf_pkg::RESQ_DEPTH + 1);
	localparam int RESET_W   = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
	localparam logic [CW-1:0] W_LAST_RST = CW'(RESET_W - 1);
	localparam logic [RW-1:0] H_LAST_RST = RW'(479);
	localparam int PROD_W    = wsf_pkg::SUM_W + wsf_pkg::MUL_W;
	localparam logic [PROD_W-1:0] DIV10_MUL_EXT = PROD_W'(wsf_pkg::DIV10_MUL);

	// frame geometry and position
	logic [CW-1:0] w_last_q;
	logic [RW-1:0] h_last_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] w_last_d;
	logic [RW-1:0] h_last_d;
	logic [31:0]   wv;
	logic [RW-1:0] hv;
	logic          in_acc;
	wsf_pkg::pos_flags_t fl_s0;

	// stage 1: line store data back
	logic                 v_s1;
	logic [PW-1:0]        p_s1;
	logic [CW-1:0]        col_s1;
	logic [RW-1:0]        row_s1;
	wsf_pkg::pos_flags_t  fl_s1;
	logic [2*PW-1:0]      ls_rdata;
	logic [PW-1:0]        top;
	logic [PW-1:0]        mid;
	logic [PW-1:0]        win_q [6];
	logic [wsf_pkg::SUM_W-1:0] sum;

	// stage 2: divide and push
	logic                 v_s2;
	logic [PW-1:0]        p_s2;
	logic [CW-1:0]        col_s2;
	logic [RW-1:0]        row_s2;
	wsf_pkg::pos_flags_t  fl_s2;
	logic [wsf_pkg::SUM_W-1:0] sum_s2;
	logic [PROD_W-1:0]    prod;
	logic [PW-1:0]        quot;
	wsf_pkg::res_push_t   push;

	// queue
	wsf_pkg::res_t        head;
	logic [QCW-1:0]       q_count;
	logic [QCW+1:0]       q_need;

	// register decode with clamping
	always_comb begin
		wv = 32'(cfg_wdata[wsf_pkg::WIDTH_REG_W-1:0]);
		hv = cfg_wdata[RW-1:0];
		if (wv < 32'd3) begin
			w_last_d = CW'(2);
		end else if (wv > 32'(MAX_WIDTH)) begin
			w_last_d = CW'(MAX_WIDTH - 1);
		end else begin
			w_last_d = CW'(wv - 32'd1);
		end
		h_last_d = (hv < RW'(3)) ? RW'(2) : hv - RW'(1);
	end

	assign in_acc = in_valid && in_ready;

	// accept while the queue can take every result still to come
	assign q_need   = (QCW+2)'(q_count) + (QCW+2)'(3) * (QCW+2)'(v_s1)
	                + (QCW+2)'(3) * (QCW+2)'(v_s2) + (QCW+2)'(3);
	assign in_ready = (q_need <= (QCW+2)'(wsf_pkg::RESQ_DEPTH));

	// position flags of the incoming pixel
	always_comb begin
		fl_s0.row_first = (row_q == '0);
		fl_s0.row_ge2   = (row_q >= RW'(2));
		fl_s0.row_last  = (row_q == h_last_q);
		fl_s0.col_first = (col_q == '0);
		fl_s0.col_ge2   = (col_q >= CW'(2));
		fl_s0.col_last  = (col_q == w_last_q);
	end

	// configuration and raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= W_LAST_RST;
			h_last_q <= H_LAST_RST;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				wsf_pkg::CFG_IDX_WIDTH:  w_last_q <= w_last_d;
				wsf_pkg::CFG_IDX_HEIGHT: h_last_q <= h_last_d;
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (col_q == w_last_q) begin
				col_q <= '0;
				row_q <= (row_q == h_last_q) ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// line stores: {older, newer} per column, read-modify-write one column apart
	wsf_ram #(
		.WIDTH(2 * PW),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (v_s1),
		.waddr (col_s1),
		.wdata ({mid, p_s1}),
		.re    (in_acc),
		.raddr (col_q),
		.rdata (ls_rdata)
	);

	assign top = ls_rdata[2*PW-1:PW];
	assign mid = ls_rdata[PW-1:0];

	// stage 1 and stage 2 valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
			v_s2 <= v_s1;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			p_s1   <= pixel_in;
			col_s1 <= col_q;
			row_s1 <= row_q;
			fl_s1  <= fl_s0;
		end
	end

	// window sum, center counted twice
	assign sum = wsf_pkg::SUM_W'(win_q[0]) + wsf_pkg::SUM_W'(win_q[1])
	           + wsf_pkg::SUM_W'(win_q[2]) + wsf_pkg::SUM_W'(win_q[3])
	           + wsf_pkg::SUM_W'(win_q[4]) + wsf_pkg::SUM_W'(win_q[5])
	           + wsf_pkg::SUM_W'(top) + wsf_pkg::SUM_W'(mid)
	           + wsf_pkg::SUM_W'(p_s1) + wsf_pkg::SUM_W'(win_q[1]);

	// window shift: [0..2] column c-1, [3..5] column c-2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (v_s1) begin
			win_q[3] <= win_q[0];
			win_q[4] <= win_q[1];
			win_q[5] <= win_q[2];
			win_q[0] <= top;
			win_q[1] <= mid;
			win_q[2] <= p_s1;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (v_s1) begin
			p_s2   <= p_s1;
			col_s2 <= col_s1;
			row_s2 <= row_s1;
			fl_s2  <= fl_s1;
			sum_s2 <= sum;
		end
	end

	// divide by ten via reciprocal
	assign prod = PROD_W'(sum_s2) * PROD_W'(DIV10_MUL_EXT);
	assign quot = prod[wsf_pkg::DIV10_SHIFT +: PW];

	// results of one transaction, in order, packed to the front
	always_comb begin
		wsf_pkg::res_t [wsf_pkg::MAX_RUN-1:0] cand;
		logic [wsf_pkg::MAX_RUN-1:0]          cv;
		logic [RW-1:0]                        row_up;
		logic [wsf_pkg::RUN_CNT_W-1:0]        n;
		logic                                 border;

		row_up = row_s2 - RW'(1);
		border = fl_s2.col_first || fl_s2.col_last;

		// previous row: left border zero or filtered pixel
		cand[0].pixel = fl_s2.col_first ? '0 : quot;
		cand[0].row   = row_up;
		cand[0].col   = fl_s2.col_first ? '0 : wsf_pkg::COL_OUT_W'(col_s2 - CW'(1));
		cand[0].last  = 1'b0;
		cv[0]         = v_s2 && fl_s2.row_ge2 && (fl_s2.col_first || fl_s2.col_ge2);

		// previous row: right border zero
		cand[1].pixel = '0;
		cand[1].row   = row_up;
		cand[1].col   = wsf_pkg::COL_OUT_W'(col_s2);
		cand[1].last  = 1'b0;
		cv[1]         = v_s2 && fl_s2.row_ge2 && fl_s2.col_last;

		// first or last row passes the pixel itself, zero at border columns
		cand[2].pixel = border ? '0 : p_s2;
		cand[2].row   = row_s2;
		cand[2].col   = wsf_pkg::COL_OUT_W'(col_s2);
		cand[2].last  = 1'b0;
		cv[2]         = v_s2 && (fl_s2.row_first || fl_s2.row_last);

		push = '0;
		n    = '0;
		for (int i = 0; i < wsf_pkg::MAX_RUN; i++) begin
			if (cv[i]) begin
				push.item[n] = cand[i];
				n = n + wsf_pkg::RUN_CNT_W'(1);
			end
		end
		if (n != '0) begin
			push.item[n - wsf_pkg::RUN_CNT_W'(1)].last = 1'b1;
		end
		push.n = n;
	end

	// output buffering
	wsf_resq #(
		.DEPTH(wsf_pkg::RESQ_DEPTH)
	) u_resq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (out_ready),
		.head       (head),
		.head_valid (out_valid),
		.count      (q_count)
	);

	assign pixel_out   = head.pixel;
	assign out_row     = head.row;
	assign out_col     = head.col;
	assign last_of_run = head.last;

	// checks
	`WSF_ASSERT(a_col_in_row, col_q <= w_last_q, "column counter ran past the row end")
	`WSF_ASSERT(a_q_room, (32'(q_count) + 32'(push.n)) <= 32'(wsf_pkg::RESQ_DEPTH), "result queue overflow")
	`WSF_ASSERT_NEXT(a_wrap_row, in_acc && !cfg_we && (col_q == w_last_q), col_q == '0, "row end did not wrap the column")

endmodule
